// File: src/bitonic_run_merge_sorter_core_assert.svh
// assertion macros for the bitonic run merge sorter checker
// expects clk and arst_n in the scope where the macros are used
`ifndef BITONIC_RUN_MERGE_SORTER_CORE_ASSERT_SVH
`define BITONIC_RUN_MERGE_SORTER_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define BRMS_CHK_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("brms check failed");

// antecedent implies consequent in the next cycle
`define BRMS_CHK_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("brms check failed");

`endif

// File: src/brms_pkg.sv
// shared types and constants of the bitonic run merge sorter
// no dependencies
`timescale 1ns / 1ps

package brms_pkg;

	localparam int MAX_KEYS = 4096;
	localparam int KEY_W    = 32;
	localparam int ADDR_W   = $clog2(MAX_KEYS);
	localparam int CNT_W    = ADDR_W + 1;
	localparam int SPAN_W   = ADDR_W + 2;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_READ = 1'b1;

	typedef struct packed {
		logic             command;
		logic [KEY_W-1:0] key;
	} req_t;

	typedef struct packed {
		logic [KEY_W-1:0] sorted_key;
		logic             last;
		logic             empty_res;
		logic             overflow;
	} rsp_t;

	typedef struct packed {
		logic              load_wr;
		logic [ADDR_W-1:0] load_addr;
		logic [KEY_W-1:0]  load_key;
		logic              sort_init;
		logic              prime;
		logic              merge;
		logic              fetch;
		logic [ADDR_W-1:0] fetch_addr;
		logic [CNT_W-1:0]  n;
	} dp_cmd_t;

	typedef struct packed {
		logic             run_last;
		logic             sort_done;
		logic [KEY_W-1:0] rd_key;
	} dp_sts_t;

endpackage

// File: src/brms_datapath.sv
// datapath: key and scratch memories, merge indices and compare
// depends on brms_pkg
`timescale 1ns / 1ps

module brms_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  brms_pkg::dp_cmd_t cmd,
	output brms_pkg::dp_sts_t sts
);
	import brms_pkg::*;

	logic [KEY_W-1:0]  mem0 [MAX_KEYS];
	logic [KEY_W-1:0]  mem1 [MAX_KEYS];
	logic [KEY_W-1:0]  rd0a_q, rd0b_q, rd1a_q, rd1b_q;
	logic [SPAN_W-1:0] width_q, lo_q;
	logic [CNT_W-1:0]  mid_q, hi_q, a_q, b_q, o_q;
	logic              bank_q;

	logic [SPAN_W-1:0] n_s, mid_full, hi_full, lo_next, width_next;
	logic [CNT_W-1:0]  mid_c, hi_c, a_n, b_n;
	logic [KEY_W-1:0]  src_a, src_b, wr_data;
	logic              a_ok, b_ok, take_b, run_last, pass_last;
	logic [ADDR_W-1:0] ra, rb, w0_addr;
	logic [KEY_W-1:0]  w0_data;
	logic              w0_en, w1_en;

	always_comb begin
		n_s        = {1'b0, cmd.n};
		width_next = width_q << 1;
		mid_full   = lo_q + width_q;
		hi_full    = lo_q + width_next;
		mid_c      = (mid_full > n_s) ? cmd.n : mid_full[CNT_W-1:0];
		hi_c       = (hi_full > n_s) ? cmd.n : hi_full[CNT_W-1:0];
		lo_next    = hi_full;
		pass_last  = (lo_next >= n_s);
		src_a      = bank_q ? rd1a_q : rd0a_q;
		src_b      = bank_q ? rd1b_q : rd0b_q;
		a_ok       = (a_q < mid_q);
		b_ok       = (b_q < hi_q);
		take_b     = b_ok && (!a_ok || (src_b < src_a));
		a_n        = take_b ? a_q : a_q + CNT_W'(1);
		b_n        = take_b ? b_q + CNT_W'(1) : b_q;
		wr_data    = take_b ? src_b : src_a;
		run_last   = ((o_q + CNT_W'(1)) == hi_q);
		if (cmd.fetch) begin
			ra = cmd.fetch_addr;
		end else if (cmd.prime) begin
			ra = lo_q[ADDR_W-1:0];
		end else begin
			ra = a_n[ADDR_W-1:0];
		end
		rb      = cmd.prime ? mid_c[ADDR_W-1:0] : b_n[ADDR_W-1:0];
		w0_en   = cmd.load_wr || (cmd.merge && bank_q);
		w0_addr = cmd.load_wr ? cmd.load_addr : o_q[ADDR_W-1:0];
		w0_data = cmd.load_wr ? cmd.load_key : wr_data;
		w1_en   = cmd.merge && !bank_q;
	end

	always_ff @(posedge clk) begin
		if (w0_en) begin
			mem0[w0_addr] <= w0_data;
		end
		rd0a_q <= mem0[ra];
		rd0b_q <= mem0[rb];
	end

	always_ff @(posedge clk) begin
		if (w1_en) begin
			mem1[o_q[ADDR_W-1:0]] <= wr_data;
		end
		rd1a_q <= mem1[ra];
		rd1b_q <= mem1[rb];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= '0;
			lo_q    <= '0;
			mid_q   <= '0;
			hi_q    <= '0;
			a_q     <= '0;
			b_q     <= '0;
			o_q     <= '0;
			bank_q  <= 1'b0;
		end else if (cmd.sort_init) begin
			width_q <= SPAN_W'(1);
			lo_q    <= '0;
			bank_q  <= 1'b0;
		end else if (cmd.prime) begin
			mid_q <= mid_c;
			hi_q  <= hi_c;
			a_q   <= lo_q[CNT_W-1:0];
			b_q   <= mid_c;
			o_q   <= lo_q[CNT_W-1:0];
		end else if (cmd.merge) begin
			a_q <= a_n;
			b_q <= b_n;
			o_q <= o_q + CNT_W'(1);
			if (run_last) begin
				if (pass_last) begin
					lo_q    <= '0;
					width_q <= width_next;
					bank_q  <= ~bank_q;
				end else begin
					lo_q <= lo_next;
				end
			end
		end
	end

	assign sts.run_last  = run_last;
	assign sts.sort_done = run_last && pass_last && (width_next >= n_s);
	assign sts.rd_key    = bank_q ? rd1a_q : rd0a_q;

endmodule

// File: src/brms_controller.sv
// controller: batch bookkeeping, sort sequencing and response register
// depends on brms_pkg
`timescale 1ns / 1ps

module brms_controller (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  brms_pkg::req_t    req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output brms_pkg::rsp_t    rsp,
	output brms_pkg::dp_cmd_t cmd,
	input  brms_pkg::dp_sts_t sts
);
	import brms_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PRIME = 3'd1;
	localparam logic [2:0] ST_MERGE = 3'd2;
	localparam logic [2:0] ST_FETCH = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	logic [2:0]       state_q;
	logic [CNT_W-1:0] count_q, rp_q;
	logic             sorted_q, dropped_q, rsp_valid_q;
	rsp_t             rsp_q;
	logic             acc, is_load, full, is_last;

	always_comb begin
		req_ready = (state_q == ST_IDLE) && ((req.command == CMD_LOAD) || !rsp_valid_q);
		acc       = req_valid && req_ready;
		is_load   = (req.command == CMD_LOAD);
		full      = (count_q == CNT_W'(MAX_KEYS));
		is_last   = ((rp_q + CNT_W'(1)) == count_q);

		cmd            = '0;
		cmd.n          = count_q;
		cmd.load_key   = req.key;
		cmd.load_addr  = sorted_q ? '0 : count_q[ADDR_W-1:0];
		cmd.load_wr    = acc && is_load && (sorted_q || !full);
		cmd.sort_init  = acc && !is_load && (count_q != '0) && !sorted_q;
		cmd.prime      = (state_q == ST_PRIME);
		cmd.merge      = (state_q == ST_MERGE);
		cmd.fetch      = (state_q == ST_FETCH);
		cmd.fetch_addr = rp_q[ADDR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rp_q        <= '0;
			sorted_q    <= 1'b0;
			dropped_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc && is_load) begin
						if (sorted_q) begin
							count_q   <= CNT_W'(1);
							rp_q      <= '0;
							sorted_q  <= 1'b0;
							dropped_q <= 1'b0;
						end else if (full) begin
							dropped_q <= 1'b1;
						end else begin
							count_q <= count_q + CNT_W'(1);
						end
					end else if (acc) begin
						if (count_q == '0) begin
							rsp_valid_q <= 1'b1;
							dropped_q   <= 1'b0;
						end else if (!sorted_q) begin
							sorted_q <= 1'b1;
							rp_q     <= '0;
							state_q  <= (count_q == CNT_W'(1)) ? ST_FETCH : ST_PRIME;
						end else begin
							state_q <= ST_FETCH;
						end
					end
				end
				ST_PRIME: begin
					state_q <= ST_MERGE;
				end
				ST_MERGE: begin
					if (sts.run_last) begin
						state_q <= sts.sort_done ? ST_FETCH : ST_PRIME;
					end
				end
				ST_FETCH: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					rsp_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
					if (is_last) begin
						count_q   <= '0;
						rp_q      <= '0;
						sorted_q  <= 1'b0;
						dropped_q <= 1'b0;
					end else begin
						rp_q <= rp_q + CNT_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && acc && !is_load && (count_q == '0)) begin
			rsp_q.sorted_key <= '0;
			rsp_q.last       <= 1'b0;
			rsp_q.empty_res  <= 1'b1;
			rsp_q.overflow   <= dropped_q;
		end else if (state_q == ST_OUT) begin
			rsp_q.sorted_key <= sts.rd_key;
			rsp_q.last       <= is_last;
			rsp_q.empty_res  <= 1'b0;
			rsp_q.overflow   <= dropped_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: src/bitonic_run_merge_sorter_core.sv
// Sorting engine for 32-bit unsigned keys. A load beat appends a key to the batch; loads
// past 4096 keys are dropped and reported in the overflow bit. The first read beat after
// loading sorts the batch with bottom-up merge passes that ping-pong between two
// single-write, dual-read memories: ceil(log2 n) passes, each of which primes every merged
// run and then merges its keys. After the sort a read beat passes through the fetch state,
// the memory read register and the response register, and the next read waits until that
// result is taken. The response register lets load beats continue while a read result
// waits. After the last key is read the batch clears.
// top level; depends on brms_pkg, brms_controller and brms_datapath
`timescale 1ns / 1ps

module bitonic_run_merge_sorter_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  brms_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output brms_pkg::rsp_t rsp
);
	import brms_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	brms_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cmd       (cmd),
		.sts       (sts)
	);

	brms_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule

// File: src/brms_checker.sv
// port-level checker for the sorter, bound to the top level
// depends on brms_pkg and bitonic_run_merge_sorter_core_assert.svh
`timescale 1ns / 1ps
`include "bitonic_run_merge_sorter_core_assert.svh"

module brms_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input brms_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input brms_pkg::rsp_t rsp
);
	import brms_pkg::*;

	`BRMS_CHK_NEXT(rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
	`BRMS_CHK_NOW(empty_clean, rsp_valid && rsp.empty_res, (rsp.sorted_key == '0) && !rsp.last)
	`BRMS_CHK_NEXT(load_no_rsp, req_valid && req_ready && (req.command == CMD_LOAD) && !rsp_valid, !rsp_valid)
	`BRMS_CHK_NOW(read_needs_room, req_valid && req_ready && (req.command == CMD_READ), !rsp_valid)

endmodule

bind bitonic_run_merge_sorter_core brms_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
